/* rtl/svr_pkg.sv */
package svr_pkg;

  localparam int SVR_QUEUE_DEPTH = 2;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [16:0] MAX_SHOWN     = 17'd99999;
  localparam logic [5:0]  TIMEOUT_LIMIT = 6'd50;

  typedef enum logic [1:0] {
    MODE_COUNTER = 2'd0,
    MODE_GOAL    = 2'd1,
    MODE_TEST    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_TEST  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [16:0] value;
    mode_t       mode;
  } cmd_t;

endpackage

/* rtl/svr_front.sv */
module svr_front
  import svr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [1:0]  in_mode_value,
  input  logic [31:0] in_counter_value,
  input  logic [31:0] in_goal_value,
  input  logic [31:0] in_remote_count,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  mode_t       mode_r, mode_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [5:0]  ticks_r, ticks_nxt;
  logic [5:0]  ticks_inc;
  logic [31:0] sel;
  logic [16:0] clamped;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign sel       = (mode_r == MODE_COUNTER) ? in_counter_value : in_goal_value;
  assign ticks_inc = ticks_r + 6'd1;

  always_comb begin
    if (sel[31]) begin
      clamped = '0;
    end else if (sel > {15'd0, MAX_SHOWN}) begin
      clamped = MAX_SHOWN;
    end else begin
      clamped = sel[16:0];
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    prev_nxt  = prev_r;
    ticks_nxt = ticks_r;
    q_cmd.kind  = KIND_NONE;
    q_cmd.value = clamped;
    if (in_opcode == OP_SET) begin
      mode_nxt = mode_t'(in_mode_value);
    end else begin
      case (mode_r)
        MODE_COUNTER, MODE_GOAL: begin
          q_cmd.kind = KIND_VALUE;
        end
        MODE_TEST: begin
          q_cmd.kind = KIND_TEST;
          prev_nxt   = in_remote_count;
          if (in_remote_count == prev_r) begin
            if (ticks_inc > TIMEOUT_LIMIT) begin
              ticks_nxt = '0;
              mode_nxt  = MODE_COUNTER;
            end else begin
              ticks_nxt = ticks_inc;
            end
          end
        end
        default: begin
          q_cmd.kind = KIND_NONE;
        end
      endcase
    end
    q_cmd.mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_COUNTER;
      prev_r  <= '0;
      ticks_r <= '0;
    end else if (q_push) begin
      mode_r  <= mode_nxt;
      prev_r  <= prev_nxt;
      ticks_r <= ticks_nxt;
    end
  end

endmodule

/* rtl/svr_queue.sv */
module svr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt;
  logic [PW-1:0]    rd_r, rd_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CW'(DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_r];

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_nxt = (wr_r == LAST) ? '0 : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LAST) ? '0 : rd_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

/* rtl/svr_back.sv */
module svr_back
  import svr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_frame_sent,
  output logic [7:0] out_seg_digit0,
  output logic [7:0] out_seg_digit1,
  output logic [7:0] out_seg_digit2,
  output logic [7:0] out_seg_digit3,
  output logic [7:0] out_seg_digit4,
  output logic [1:0] out_mode_now
);

  localparam logic [34:0] RECIP_1000 = 35'd134218;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // two decimal digits of a value below 100, tens via x*205 >> 11
  function automatic logic [7:0] two_digits(input logic [6:0] x);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    p = ({8'd0, x} << 7) + ({8'd0, x} << 6) + ({8'd0, x} << 3)
      + ({8'd0, x} << 2) + {8'd0, x};
    t = p[14:11];
    o = x - ({3'd0, t} << 3) - ({3'd0, t} << 1);
    return {t, o[3:0]};
  endfunction

  logic        advance;

  logic        v1_r, v2_r, v3_r, out_valid_r;
  cmd_t        c1_r, c2_r, c3_r;
  logic [6:0]  hi1_r;
  logic [7:0]  hid2_r, hid3_r;
  logic [9:0]  lo2_r;
  logic [3:0]  d2_3_r;
  logic [6:0]  rem3_r;

  logic [34:0] prod;
  logic [16:0] hi_k;
  logic [16:0] lo_full;
  logic [15:0] lo41;
  logic [3:0]  d2;
  logic [9:0]  rem_full;

  logic [3:0]  dg0, dg1, dg3, dg4;
  logic [7:0]  r_digits;
  logic [7:0]  s0, s1, s2, s3, s4;
  logic        fs;

  logic       fs_r;
  logic [7:0] seg0_r, seg1_r, seg2_r, seg3_r, seg4_r;
  logic [1:0] mode_out_r;

  assign advance = !out_valid_r || !out_stall;
  assign q_pop   = advance && q_not_empty;

  assign prod    = {18'd0, q_cmd.value} * RECIP_1000;

  assign hi_k    = ({10'd0, hi1_r} << 10) - ({10'd0, hi1_r} << 4) - ({10'd0, hi1_r} << 3);
  assign lo_full = c1_r.value - hi_k;

  assign lo41    = ({6'd0, lo2_r} << 5) + ({6'd0, lo2_r} << 3) + {6'd0, lo2_r};
  assign d2      = lo41[15:12];
  assign rem_full = lo2_r - ({6'd0, d2} << 6) - ({6'd0, d2} << 5) - ({6'd0, d2} << 2);

  assign r_digits = two_digits(rem3_r);
  assign dg0 = hid3_r[7:4];
  assign dg1 = hid3_r[3:0];
  assign dg3 = r_digits[7:4];
  assign dg4 = r_digits[3:0];

  always_comb begin
    s0 = 8'h00;
    s1 = 8'h00;
    s2 = 8'h00;
    s3 = 8'h00;
    s4 = 8'h00;
    fs = 1'b0;
    case (c3_r.kind)
      KIND_VALUE: begin
        fs = 1'b1;
        s0 = (dg0 == 4'd0) ? 8'h00 : seg_of(dg0);
        s1 = (dg0 == 4'd0 && dg1 == 4'd0) ? 8'h00 : seg_of(dg1);
        s2 = (dg0 == 4'd0 && dg1 == 4'd0 && d2_3_r == 4'd0) ? 8'h00 : seg_of(d2_3_r);
        s3 = (dg0 == 4'd0 && dg1 == 4'd0 && d2_3_r == 4'd0 && dg3 == 4'd0)
             ? 8'h00 : seg_of(dg3);
        s4 = seg_of(dg4);
      end
      KIND_TEST: begin
        fs = 1'b1;
        s0 = seg_of(4'd0);
        s1 = seg_of(4'd0);
        s2 = seg_of(4'd0);
        s3 = seg_of(4'd0);
        s4 = seg_of(4'd0);
      end
      default: begin
        fs = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= q_not_empty;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c1_r       <= q_cmd;
      hi1_r      <= prod[33:27];
      c2_r       <= c1_r;
      lo2_r      <= lo_full[9:0];
      hid2_r     <= two_digits(hi1_r);
      c3_r       <= c2_r;
      hid3_r     <= hid2_r;
      d2_3_r     <= d2;
      rem3_r     <= rem_full[6:0];
      fs_r       <= fs;
      seg0_r     <= s0;
      seg1_r     <= s1;
      seg2_r     <= s2;
      seg3_r     <= s3;
      seg4_r     <= s4;
      mode_out_r <= c3_r.mode;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_sent = fs_r;
  assign out_seg_digit0 = seg0_r;
  assign out_seg_digit1 = seg1_r;
  assign out_seg_digit2 = seg2_r;
  assign out_seg_digit3 = seg3_r;
  assign out_seg_digit4 = seg4_r;
  assign out_mode_now   = mode_out_r;

endmodule

/* rtl/seven_segment_value_renderer.sv */
// Five-digit seven-segment renderer. Every input beat gives exactly one result beat, in
// order. The front end takes one beat per clock while the queue is not full, updates
// mode and remote-test state and queues a command; the back end converts the clamped
// value to decimal digits in a four-register pipeline (divide by 1000 through a
// reciprocal multiply, then the remaining digits by shift-add steps), and one beat per
// clock is sustained when neither side stalls. Input stall rises only while the
// command queue is full.
module seven_segment_value_renderer
  import svr_pkg::*;
#(
  parameter int QUEUE_DEPTH = SVR_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [1:0]  in_mode_value,
  input  logic [31:0] in_counter_value,
  input  logic [31:0] in_goal_value,
  input  logic [31:0] in_remote_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_sent,
  output logic [7:0]  out_seg_digit0,
  output logic [7:0]  out_seg_digit1,
  output logic [7:0]  out_seg_digit2,
  output logic [7:0]  out_seg_digit3,
  output logic [7:0]  out_seg_digit4,
  output logic [1:0]  out_mode_now
);

  logic q_push, q_pop, q_full, q_not_empty;
  cmd_t push_cmd, pop_cmd;

  svr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_mode_value    (in_mode_value),
    .in_counter_value (in_counter_value),
    .in_goal_value    (in_goal_value),
    .in_remote_count  (in_remote_count),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (push_cmd)
  );

  svr_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  svr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_cmd          (pop_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_sent (out_frame_sent),
    .out_seg_digit0 (out_seg_digit0),
    .out_seg_digit1 (out_seg_digit1),
    .out_seg_digit2 (out_seg_digit2),
    .out_seg_digit3 (out_seg_digit3),
    .out_seg_digit4 (out_seg_digit4),
    .out_mode_now   (out_mode_now)
  );

endmodule

/* sim/tb_seven_segment_value_renderer.sv */
module tb_seven_segment_value_renderer;
  import svr_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [7:0] SEG_PATTERN [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  typedef struct packed {
    logic            sent;
    logic [4:0][7:0] seg;
    mode_t           mode;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = OP_SET;
  logic [1:0]  in_mode_value = 2'b00;
  logic [31:0] in_counter_value = '0;
  logic [31:0] in_goal_value = '0;
  logic [31:0] in_remote_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_frame_sent;
  logic [7:0]  out_seg_digit0;
  logic [7:0]  out_seg_digit1;
  logic [7:0]  out_seg_digit2;
  logic [7:0]  out_seg_digit3;
  logic [7:0]  out_seg_digit4;
  logic [1:0]  out_mode_now;

  seven_segment_value_renderer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_mode_value    (in_mode_value),
    .in_counter_value (in_counter_value),
    .in_goal_value    (in_goal_value),
    .in_remote_count  (in_remote_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_sent   (out_frame_sent),
    .out_seg_digit0   (out_seg_digit0),
    .out_seg_digit1   (out_seg_digit1),
    .out_seg_digit2   (out_seg_digit2),
    .out_seg_digit3   (out_seg_digit3),
    .out_seg_digit4   (out_seg_digit4),
    .out_mode_now     (out_mode_now)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // display state as the block should hold it
  mode_t       shown_mode = MODE_COUNTER;
  logic [31:0] last_remote = '0;
  logic [5:0]  quiet_ticks = '0;

  frame_t pending_frames[$];
  int     mismatches = 0;
  int     beats_sent = 0;
  int     beats_checked = 0;
  int     frames_rendered = 0;
  int     remote_timeouts = 0;
  bit     idling_on = 1'b1;
  int     hold_request = 0;

  function automatic logic [16:0] clamp_shown(logic [31:0] raw);
    if (raw[31]) return '0;
    if (raw > 32'(MAX_SHOWN)) return MAX_SHOWN;
    return raw[16:0];
  endfunction

  function automatic logic [4:0][7:0] render_digits(logic [16:0] value);
    logic [4:0][7:0] segs;
    int digit [5];
    int rest;
    bit leading;
    rest = value;
    for (int k = 4; k >= 0; k--) begin
      digit[k] = rest % 10;
      rest = rest / 10;
    end
    leading = 1'b1;
    for (int k = 0; k < 5; k++) begin
      if (leading && digit[k] == 0 && k < 4) begin
        segs[k] = 8'h00;
      end else begin
        leading = 1'b0;
        segs[k] = SEG_PATTERN[digit[k]];
      end
    end
    return segs;
  endfunction

  function automatic frame_t predict_frame(logic op, logic [1:0] mv, logic [31:0] cv,
                                           logic [31:0] gv, logic [31:0] rc);
    frame_t f;
    f = '0;
    if (op == OP_SET) begin
      shown_mode = mode_t'(mv);
    end else if (shown_mode == MODE_COUNTER || shown_mode == MODE_GOAL) begin
      f.sent = 1'b1;
      f.seg = render_digits(clamp_shown(shown_mode == MODE_COUNTER ? cv : gv));
    end else if (shown_mode == MODE_TEST) begin
      f.sent = 1'b1;
      for (int k = 0; k < 5; k++) f.seg[k] = SEG_PATTERN[0];
      if (rc == last_remote) begin
        quiet_ticks = quiet_ticks + 6'd1;
        if (quiet_ticks > TIMEOUT_LIMIT) begin
          shown_mode = MODE_COUNTER;
          quiet_ticks = '0;
          remote_timeouts++;
        end
      end
      last_remote = rc;
    end
    f.mode = shown_mode;
    if (f.sent) frames_rendered++;
    return f;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at result beat %0d: %s", beats_checked, what);
    mismatches++;
  endtask

  task automatic send_beat(logic op, logic [1:0] mv, logic [31:0] cv, logic [31:0] gv,
                           logic [31:0] rc);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_mode_value    <= mv;
    in_counter_value <= cv;
    in_goal_value    <= gv;
    in_remote_count  <= rc;
    do @(posedge clk); while (in_stall);
    pending_frames.push_back(predict_frame(op, mv, cv, gv, rc));
    beats_sent++;
  endtask

  task automatic set_mode(mode_t m);
    send_beat(OP_SET, m, $urandom, $urandom, $urandom);
  endtask

  task automatic tick(logic [31:0] cv, logic [31:0] gv, logic [31:0] rc);
    send_beat(OP_TICK, 2'($urandom), cv, gv, rc);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 9);
      1: return $urandom_range(10, 999);
      2: return $urandom_range(1000, 99999);
      3: return $urandom_range(99990, 100010);
      4: return 32'd0 - $urandom_range(1, 1000);
      5: return {1'b1, 31'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_remote();
    if ($urandom_range(0, 1) == 0) return last_remote;
    return $urandom;
  endfunction

  task automatic test_directed();
    tick(32'd0, $urandom, $urandom);
    tick(32'd7, $urandom, $urandom);
    tick(32'd10, $urandom, $urandom);
    tick(32'd305, $urandom, $urandom);
    tick(32'd99999, $urandom, $urandom);
    tick(32'd100000, $urandom, $urandom);
    tick(32'hFFFF_FFFF, $urandom, $urandom);
    tick(32'h8000_0000, $urandom, $urandom);
    tick(32'h7FFF_FFFF, $urandom, $urandom);
    tick(32'd40960, $urandom, $urandom);
    set_mode(MODE_GOAL);
    tick($urandom, 32'd0, $urandom);
    tick($urandom, 32'd1000, $urandom);
    tick($urandom, 32'h8000_0001, $urandom);
    tick($urandom, 32'd99998, $urandom);
    set_mode(MODE_NONE);
    tick($urandom, $urandom, $urandom);
    set_mode(MODE_TEST);
    tick($urandom, $urandom, 32'd0);
    tick($urandom, $urandom, 32'd5);
    tick($urandom, $urandom, 32'd5);
    set_mode(MODE_COUNTER);
    tick(32'd1, $urandom, $urandom);
  endtask

  task automatic test_mixed_random(int count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0)
        send_beat(OP_SET, 2'($urandom), $urandom, $urandom, $urandom);
      else
        tick(pick_value(), pick_value(), pick_remote());
    end
  endtask

  // unchanged-count runs in remote-test mode; the count carries over between runs
  task automatic test_remote_timeout(int count);
    int sent;
    int run;
    sent = 0;
    while (sent < count) begin
      set_mode(MODE_TEST);
      sent++;
      run = $urandom_range(20, 80);
      repeat (run) begin
        case ($urandom_range(0, 19))
          0: send_beat(OP_SET, 2'($urandom), $urandom, $urandom, $urandom);
          1: tick(pick_value(), pick_value(), $urandom);
          default: tick(pick_value(), pick_value(), last_remote);
        endcase
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_request = 120;
    test_mixed_random(40);
  endtask

  task automatic test_drain_pause();
    test_mixed_random(15);
    idle_input();
    wait_drained();
    test_mixed_random(15);
  endtask

  task automatic test_full_rate();
    idling_on = 1'b0;
    test_mixed_random(100);
    test_remote_timeout(100);
  endtask

  // receiver: random stall bursts plus the long hold asked for by the back-pressure test
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end else if (!idling_on) begin
        stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_frames.pop_front();
        if (out_frame_sent !== want.sent)
          report_mismatch($sformatf("frame_sent exp %0b got %0b", want.sent, out_frame_sent));
        if (out_seg_digit0 !== want.seg[0])
          report_mismatch($sformatf("seg_digit0 exp %02h got %02h", want.seg[0], out_seg_digit0));
        if (out_seg_digit1 !== want.seg[1])
          report_mismatch($sformatf("seg_digit1 exp %02h got %02h", want.seg[1], out_seg_digit1));
        if (out_seg_digit2 !== want.seg[2])
          report_mismatch($sformatf("seg_digit2 exp %02h got %02h", want.seg[2], out_seg_digit2));
        if (out_seg_digit3 !== want.seg[3])
          report_mismatch($sformatf("seg_digit3 exp %02h got %02h", want.seg[3], out_seg_digit3));
        if (out_seg_digit4 !== want.seg[4])
          report_mismatch($sformatf("seg_digit4 exp %02h got %02h", want.seg[4], out_seg_digit4));
        if (out_mode_now !== want.mode)
          report_mismatch($sformatf("mode_now exp %0d got %0d", want.mode, out_mode_now));
      end
      beats_checked++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_mixed_random(550);
    test_remote_timeout(350);
    test_backpressure();
    test_drain_pause();
    test_full_rate();
    idle_input();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d beats, checked %0d results, %0d of them frames.",
             beats_sent, beats_checked, frames_rendered);
    $display("Remote-test timeouts back to counter mode: %0d.", remote_timeouts);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/svr_pkg.sv
rtl/svr_front.sv
rtl/svr_queue.sv
rtl/svr_back.sv
rtl/seven_segment_value_renderer.sv
sim/tb_seven_segment_value_renderer.sv
